[design/lzss_window_decoder_defines.svh]
// Assertion macros shared by the LZSS window decoder RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef LZSS_WINDOW_DECODER_DEFINES_SVH
`define LZSS_WINDOW_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LZWD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define LZWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/lzwd_pkg.sv]
// Package for the LZSS window decoder: token and result payload types.
// No dependencies.
package lzwd_pkg;

	// One unpacked token from the stream
	typedef struct packed {
		logic        is_literal;
		logic [7:0]  literal_byte;
		logic [11:0] copy_start;
		logic [3:0]  length_code;
	} token_t;

	// One decoded result byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       stream_end;
	} result_t;

endpackage

[design/lzwd_window.sv]
// History window of the LZSS decoder: one write port, one registered read port.
// Forwards a write to a read of the same address in the same cycle.
module lzwd_window #(
	parameter int INDEX_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [INDEX_BITS-1:0] rd_addr,
	input  logic                  wr_en,
	input  logic [INDEX_BITS-1:0] wr_addr,
	input  logic [7:0]            wr_data,
	output logic [7:0]            rd_data
);

	localparam int DEPTH = 1 << INDEX_BITS;

	logic [7:0] mem_q [DEPTH];
	logic [7:0] ram_q;
	logic       fwd_q;
	logic [7:0] fwd_data_q;

	// Storage array and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q <= mem_q[rd_addr];
		end
	end

	// Read-during-write bypass: the array returns old data, so keep the new byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : ram_q;

endmodule

[design/lzss_window_decoder.sv]
// LZSS window decoder: token in, decoded bytes out, 2^INDEX_BITS byte history.
// Depends on lzwd_pkg, lzwd_window and lzss_window_decoder_defines.svh.
//
// Usage:
//   token channel  : one unpacked token per transfer (literal, match or end marker).
//   result channel : one decoded byte per transfer; last marks the token's final byte,
//                    stream_end marks the end marker's single result (byte 0).
// Sequence:
//   A literal or end marker is taken while idle, and its result is registered from
//   the ST_ONE state once the output is free; no new token is taken until then.
//   A match of n = length_code + BREAK_EVEN_LEN + 1 bytes is taken with its first
//   window read started, then gives one byte per cycle while the result is not
//   stalled, through the single window read port, each byte also written back at
//   the write pointer.
//   The token channel stalls while a token is being worked on.
// Stall:
//   A stalled result holds in the output register; the copy sequencer waits with it.
// Reset:
//   arst_n clears the sequencer, the output valid and sets the write pointer to 1.
//   The window is not cleared; the token stream must read entries only after writing them (not enforced here).
module lzss_window_decoder
	import lzwd_pkg::*;
#(
	parameter int INDEX_BITS     = 12,
	parameter int LENGTH_BITS    = 4,
	parameter int BREAK_EVEN_LEN = 1
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    token_valid,
	output logic    token_stall,
	input  token_t  token,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

`include "lzss_window_decoder_defines.svh"

	localparam int CNT_W = $clog2((1 << LENGTH_BITS) + BREAK_EVEN_LEN);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ONE  = 2'd1;
	localparam logic [1:0] ST_COPY = 2'd2;

	logic [1:0]            state_q;
	logic [INDEX_BITS-1:0] wp_q;
	logic [INDEX_BITS-1:0] src_q;
	logic [CNT_W-1:0]      rem_q;
	logic [7:0]            one_byte_q;
	logic                  one_end_q;
	result_t               out_q;
	logic                  out_valid_q;

	logic                  tok_acc;
	logic [INDEX_BITS-1:0] tok_pos;
	logic [LENGTH_BITS-1:0] tok_code;
	logic                  tok_end;
	logic                  out_free;
	logic                  copy_step;
	logic                  rd_en;
	logic [INDEX_BITS-1:0] rd_addr;
	logic                  wr_en;
	logic [7:0]            wr_data;
	logic [7:0]            win_rd;

	// Token decode
	assign token_stall = (state_q != ST_IDLE);
	assign tok_acc     = token_valid && !token_stall;
	assign tok_pos     = INDEX_BITS'(token.copy_start);
	assign tok_code    = LENGTH_BITS'(token.length_code);
	assign tok_end     = !token.is_literal && (tok_pos == '0);
	assign out_free    = !out_valid_q || !result_stall;
	assign copy_step   = (state_q == ST_COPY) && out_free;

	// Window port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = src_q + INDEX_BITS'(1);
		wr_en   = 1'b0;
		wr_data = win_rd;
		if (tok_acc && !token.is_literal && !tok_end) begin
			rd_en   = 1'b1;
			rd_addr = tok_pos;
		end else if (copy_step && (rem_q != '0)) begin
			rd_en = 1'b1;
		end
		if (tok_acc && token.is_literal) begin
			wr_en   = 1'b1;
			wr_data = token.literal_byte;
		end else if (copy_step) begin
			wr_en = 1'b1;
		end
	end

	lzwd_window #(
		.INDEX_BITS(INDEX_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (wr_data),
		.rd_data (win_rd)
	);

	// Sequencer, write pointer and copy counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= INDEX_BITS'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tok_acc) begin
						priority if (token.is_literal) begin
							wp_q    <= wp_q + INDEX_BITS'(1);
							state_q <= ST_ONE;
						end else if (tok_end) begin
							wp_q    <= INDEX_BITS'(1);
							state_q <= ST_ONE;
						end else begin
							state_q <= ST_COPY;
						end
					end
				end
				ST_ONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (copy_step) begin
						wp_q <= wp_q + INDEX_BITS'(1);
						if (rem_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Token payload held for the sequencer
	always_ff @(posedge clk) begin
		if (tok_acc) begin
			src_q      <= tok_pos;
			rem_q      <= CNT_W'(tok_code) + CNT_W'(BREAK_EVEN_LEN);
			one_byte_q <= token.is_literal ? token.literal_byte : 8'd0;
			one_end_q  <= !token.is_literal;
		end else if (copy_step) begin
			src_q <= src_q + INDEX_BITS'(1);
			rem_q <= rem_q - CNT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_ONE) || (state_q == ST_COPY)) begin
			out_valid_q <= out_free || out_valid_q;
		end else begin
			out_valid_q <= out_valid_q && result_stall;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_ONE) && out_free) begin
			out_q.out_byte   <= one_byte_q;
			out_q.last       <= 1'b1;
			out_q.stream_end <= one_end_q;
		end else if (copy_step) begin
			out_q.out_byte   <= win_rd;
			out_q.last       <= (rem_q == '0);
			out_q.stream_end <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Checks
	`LZWD_ASSERT_NEXT(a_end_ptr, tok_acc && tok_end, wp_q == INDEX_BITS'(1),
		"end marker did not return the write pointer to one")
	`LZWD_ASSERT_NEXT(a_lit_ptr, tok_acc && token.is_literal,
		wp_q == $past(wp_q) + INDEX_BITS'(1), "literal did not advance the write pointer")
	`LZWD_ASSERT_NEXT(a_copy_done, copy_step && (rem_q == '0),
		(state_q == ST_IDLE) && result_valid && result.last, "match did not end on its last byte")
	`LZWD_ASSERT_NOW(a_end_result, result_valid && result.stream_end,
		result.last && (result.out_byte == 8'd0), "end result must be a lone zero byte")

endmodule
